// File: rtl/core/rfq_pkg.sv
package rfq_pkg;

    // Default geometry of the queue.
    localparam int SLOTS_DEF     = 16;
    localparam int MAX_FRAME_DEF = 1514;

    // Fixed field widths.
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 11;
    localparam int LIMIT_W = 16;
    localparam int DROP_W  = 32;

    // Packed stream widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 4;

    typedef enum logic [1:0] {
        PS_NONE   = 2'd0,
        PS_COMMIT = 2'd1,
        PS_DROP   = 2'd2,
        PS_REJECT = 2'd3
    } t_push_status;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;
        logic execute;
    } t_ctrl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
    } t_ctrl_status;

endpackage

// File: rtl/core/rfq_ctrl.sv
module rfq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  rfq_pkg::t_ctrl_status i_status,
    output rfq_pkg::t_ctrl_cmd    o_cmd
);
    import rfq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_state <= ST_EXEC;
                        r_ready <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_s_axis_tready   = r_ready;
    assign o_cmd.load_item   = r_ready && i_s_axis_tvalid;
    assign o_cmd.execute     = (r_state == ST_EXEC) && i_status.out_free;

    // The input is only open while the controller waits for a word.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready == (r_state == ST_IDLE))
        else $error("ready flag out of step with state");

    a_no_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_item |=> !r_ready)
        else $error("input reopened before the word was executed");

    a_exec_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> r_ready)
        else $error("input not reopened after execution");

endmodule

// File: rtl/core/rfq_datapath.sv
module rfq_datapath #(
    parameter int SLOTS     = rfq_pkg::SLOTS_DEF,
    parameter int MAX_FRAME = rfq_pkg::MAX_FRAME_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rfq_pkg::t_ctrl_cmd             i_cmd,
    output rfq_pkg::t_ctrl_status          o_status,
    input  logic [rfq_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [rfq_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    output logic [rfq_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser
);
    import rfq_pkg::*;

    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int OFS_W       = $clog2(MAX_FRAME);
    localparam int CNT_W       = $clog2(MAX_FRAME + 2);
    localparam int ADDR_W      = SLOT_W + OFS_W;
    localparam int STORE_DEPTH = SLOTS << OFS_W;
    localparam int PAD_W       = OUT_TDATA_W - BYTE_W - LEN_W - DROP_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_FRAME);

    // Frame bytes and committed lengths.
    logic [BYTE_W-1:0] r_store [STORE_DEPTH];
    logic [LEN_W-1:0]  r_slot_len [SLOTS];
    logic [BYTE_W-1:0] r_store_q;
    logic [LEN_W-1:0]  r_len_q;

    // Queue state.
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_wcount, n_wcount;
    logic [OFS_W-1:0]  r_rpos, n_rpos;
    logic [DROP_W-1:0] r_drop, n_drop;

    // Latched input word.
    logic               r_is_pop;
    logic [BYTE_W-1:0]  r_data;
    logic               r_last;
    logic [LIMIT_W-1:0] r_limit;

    // Output register.
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic               r_byte_valid, n_byte_valid;
    logic               r_frame_end, n_frame_end;
    logic               r_queue_empty, n_queue_empty;
    logic [1:0]         r_push_status, n_push_status;
    logic [LEN_W-1:0]   r_frame_len, n_frame_len;

    // Intermediate values.
    logic [SLOT_W-1:0]  head_nxt, tail_nxt;
    logic [CNT_W-1:0]   wcount_inc;
    logic               store_wr;
    logic               empty, have_byte, finish;
    logic [LEN_W-1:0]   deliver_len, rpos_ext, rpos_inc;

    assign o_status.out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_is_pop <= i_s_axis_tuser;
            r_data   <= i_s_axis_tdata[BYTE_W-1:0];
            r_limit  <= i_s_axis_tdata[BYTE_W +: LIMIT_W];
            r_last   <= i_s_axis_tlast;
        end
    end

    // Byte memory: one write port at the head, one registered read at the tail.
    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_store[{r_head, r_wcount[OFS_W-1:0]}] <= r_data;
        end
        r_store_q <= r_store[ADDR_W'({r_tail, r_rpos})];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && !r_is_pop && r_last
                && (n_push_status == PS_COMMIT)) begin
            r_slot_len[r_head] <= LEN_W'(wcount_inc);
        end
        r_len_q <= r_slot_len[r_tail];
    end

    always_comb begin
        head_nxt   = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
        tail_nxt   = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
        wcount_inc = (r_wcount <= MAX_CNT) ? r_wcount + 1'b1 : r_wcount;
        store_wr   = i_cmd.execute && !r_is_pop && (r_wcount < MAX_CNT);

        empty       = (r_tail == r_head);
        deliver_len = ({{(LIMIT_W - LEN_W){1'b0}}, r_len_q} < r_limit)
                      ? r_len_q : r_limit[LEN_W-1:0];
        rpos_ext    = LEN_W'(r_rpos);
        rpos_inc    = rpos_ext + 1'b1;
        have_byte   = !empty && (rpos_ext < deliver_len);
        finish      = !empty && (!have_byte || (rpos_inc == deliver_len));

        n_head        = r_head;
        n_tail        = r_tail;
        n_wcount      = r_wcount;
        n_rpos        = r_rpos;
        n_drop        = r_drop;
        n_out_byte    = '0;
        n_byte_valid  = 1'b0;
        n_frame_end   = 1'b0;
        n_queue_empty = 1'b0;
        n_push_status = PS_NONE;
        n_frame_len   = '0;

        if (r_is_pop) begin
            if (empty) begin
                n_queue_empty = 1'b1;
            end else begin
                n_frame_len = deliver_len;
                if (have_byte) begin
                    n_out_byte   = r_store_q;
                    n_byte_valid = 1'b1;
                    n_rpos       = rpos_inc[OFS_W-1:0];
                end
                if (finish) begin
                    n_frame_end = 1'b1;
                    n_rpos      = '0;
                    n_tail      = tail_nxt;
                end
            end
        end else begin
            n_wcount = wcount_inc;
            if (r_last) begin
                n_wcount = '0;
                if (wcount_inc > MAX_CNT) begin
                    n_push_status = PS_REJECT;
                end else if (head_nxt == r_tail) begin
                    n_drop        = r_drop + 1'b1;
                    n_push_status = PS_DROP;
                end else begin
                    n_head        = head_nxt;
                    n_push_status = PS_COMMIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_wcount    <= '0;
            r_rpos      <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_wcount    <= n_wcount;
                r_rpos      <= n_rpos;
                r_drop      <= n_drop;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out_byte    <= n_out_byte;
            r_byte_valid  <= n_byte_valid;
            r_frame_end   <= n_frame_end;
            r_queue_empty <= n_queue_empty;
            r_push_status <= n_push_status;
            r_frame_len   <= n_frame_len;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_drop, r_frame_len, r_out_byte};
    assign o_m_axis_tlast  = r_frame_end;
    assign o_m_axis_tuser  = {r_push_status, r_queue_empty, r_byte_valid};

    a_head_never_on_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != $past(r_head)) |-> (r_head != r_tail))
        else $error("commit advanced head onto the read slot");

    a_drop_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drop != $past(r_drop)) |-> (r_drop == $past(r_drop) + 1'b1))
        else $error("drop counter moved by more than one");

    a_result_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_queue_empty && (r_byte_valid || r_frame_end)))
        else $error("empty pop reported a byte or a frame end");

    a_pointer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= LAST_SLOT) && (r_tail <= LAST_SLOT))
        else $error("slot pointer out of range");

endmodule

// File: rtl/core/received_frame_queue.sv
// Received frame queue. Each input word is either a push of one frame byte
// (tuser low) or a pop of one byte of the oldest stored frame (tuser high),
// and each word yields exactly one result word. Pushed bytes land in the free
// head slot; tlast ends the frame, which is then committed, rejected when it
// is longer than MAX_FRAME, or dropped and counted when all but one of the
// SLOTS slots are already taken. A pop returns the next byte of the oldest
// frame, delivering min(stored length, read limit) bytes, and sets tlast on
// the result that frees the frame; a zero limit frees it at once. Each word
// passes through two steps: the word is latched while the byte memory and
// the slot length table are read, and then the queue is updated and the
// output register loaded. A finished result can wait in the output register
// while the next word is taken in; the block stalls only when a second
// result is ready before the first has been taken. The memories need no
// clearing after reset, so the block accepts words as soon as reset ends.
module received_frame_queue #(
    parameter int SLOTS     = rfq_pkg::SLOTS_DEF,
    parameter int MAX_FRAME = rfq_pkg::MAX_FRAME_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input words.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] data_byte, [23:8] read_limit
    input  logic [rfq_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // last_byte
    input  logic                            i_s_axis_tlast,
    // [0] req_type: 0 push, 1 pop
    input  logic                            i_s_axis_tuser,
    // Result words.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] out_byte, [18:8] frame_length, [50:19] dropped_count, rest zero
    output logic [rfq_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // frame_end
    output logic                            o_m_axis_tlast,
    // [0] byte_valid, [1] queue_empty, [3:2] push_status
    output logic [rfq_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser
);
    import rfq_pkg::*;

    t_ctrl_cmd    ctrl_cmd;
    t_ctrl_status ctrl_status;

    // The controller sequences latch and execute; the datapath owns the
    // pointers, the counters, both memories and the output register.
    rfq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (ctrl_status),
        .o_cmd           (ctrl_cmd)
    );

    rfq_datapath #(
        .SLOTS     (SLOTS),
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .o_status        (ctrl_status),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
